### design/ssrl_pkg.sv
// ----------------------------------------------------------------------------
// ssrl_pkg
// Shared types and constants for the serial shift register loader.
// ----------------------------------------------------------------------------
package ssrl_pkg;

    localparam int DEFAULT_BUFFER_BYTES = 8;
    localparam int BYTE_BITS            = 8;
    localparam int INDEX_WIDTH          = 3;
    localparam int COUNT_WIDTH          = 7;
    localparam int BIT_POS_WIDTH        = 4;
    localparam logic INVERT_RESET       = 1'b1;

    typedef enum logic [1:0] {
        KIND_TICK,
        KIND_LOAD,
        KIND_START,
        KIND_ENABLE
    } kind_t;

    typedef struct packed {
        kind_t                    kind;
        logic [INDEX_WIDTH-1:0]   byte_index;
        logic [BYTE_BITS-1:0]     byte_value;
        logic [COUNT_WIDTH-1:0]   byte_count;
        logic                     enable_value;
    } item_t;

    // logical pin levels
    typedef struct packed {
        logic enable_n;
        logic latch_clock;
        logic shift_clock;
        logic serial_data;
    } pins_t;

    typedef struct packed {
        pins_t pins;
        logic  busy;
    } res_t;

endpackage

### design/serial_shift_register_loader.sv
// ----------------------------------------------------------------------------
// serial_shift_register_loader
// Drives a chain of serial-in, parallel-out shift registers; each input beat
// loads a byte, starts a transfer, sets the enable pin or advances one tick.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------------------
//  s_       | s_valid / s_ready  | kind, byte_index, byte_value, byte_count,
//           |                    | enable_value
//  m_       | m_valid / m_ready  | serial_data, shift_clock, latch_clock,
//           |                    | enable_n, busy_res
//  cfg_     | cfg_wr_en          | cfg_wr_data (invert_pins)
//
// one beat per cycle unless m_ stalls; m_valid rises when the beat fires
// input register feeds the sequencer, result register holds the pin levels
// m_ stall backs up into the input register, then drops s_ready
// synchronous active-low reset: idle, buffer cleared, pins inverted
// ----------------------------------------------------------------------------
module serial_shift_register_loader
    import ssrl_pkg::*;
#(
    parameter int BUFFER_BYTES = DEFAULT_BUFFER_BYTES
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic                   cfg_wr_data,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [1:0]             s_kind,
    input  logic [INDEX_WIDTH-1:0] s_byte_index,
    input  logic [BYTE_BITS-1:0]   s_byte_value,
    input  logic [COUNT_WIDTH-1:0] s_byte_count,
    input  logic                   s_enable_value,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_serial_data,
    output logic                   m_shift_clock,
    output logic                   m_latch_clock,
    output logic                   m_enable_n,
    output logic                   m_busy_res
);

    logic  invert_reg;
    logic  in_valid_reg;
    item_t item_reg;
    logic  out_valid_reg;
    res_t  res_reg;
    res_t  res_next;
    logic  fire;

    assign fire    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;

    ssrl_seq #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .fire     (fire),
        .item     (item_reg),
        .res_next (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            invert_reg <= INVERT_RESET;
        end else if (cfg_wr_en) begin
            invert_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.kind         <= kind_t'(s_kind);
            item_reg.byte_index   <= s_byte_index;
            item_reg.byte_value   <= s_byte_value;
            item_reg.byte_count   <= s_byte_count;
            item_reg.enable_value <= s_enable_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            res_reg.pins <= res_next.pins ^ {4{invert_reg}};
            res_reg.busy <= res_next.busy;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_serial_data = res_reg.pins.serial_data;
    assign m_shift_clock = res_reg.pins.shift_clock;
    assign m_latch_clock = res_reg.pins.latch_clock;
    assign m_enable_n    = res_reg.pins.enable_n;
    assign m_busy_res    = res_reg.busy;

`ifndef SYNTH
    a_fire_out: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> m_valid)
        else $error("processed beat not presented");
    a_hold_in: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && m_valid && !m_ready) |-> !s_ready)
        else $error("input taken while both stages full");
    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && item_reg.kind == KIND_START) |=> m_busy_res)
        else $error("start beat did not report busy");
`endif

endmodule

### design/ssrl_seq.sv
// ----------------------------------------------------------------------------
// ssrl_seq
// Pin sequencer and send buffer: applies one beat per fire strobe and
// presents the state that follows it.
// ----------------------------------------------------------------------------
module ssrl_seq
    import ssrl_pkg::*;
#(
    parameter int BUFFER_BYTES = DEFAULT_BUFFER_BYTES
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  fire,
    input  item_t item,
    output res_t  res_next
);

    // only indices reachable through byte_index are ever stored
    localparam int STORE_BYTES = (BUFFER_BYTES < (1 << INDEX_WIDTH)) ?
                                 BUFFER_BYTES : (1 << INDEX_WIDTH);
    localparam logic [COUNT_WIDTH-1:0] BUF_LIMIT = COUNT_WIDTH'(BUFFER_BYTES);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_BEGIN,
        PH_STEP,
        PH_FINISH
    } phase_t;

    phase_t                   phase_reg,      phase_next;
    logic [COUNT_WIDTH-1:0]   byte_pos_reg,   byte_pos_next;
    logic [BIT_POS_WIDTH-1:0] bit_pos_reg,    bit_pos_next;
    logic                     half_reg,       half_next;
    logic [COUNT_WIDTH-1:0]   byte_total_reg, byte_total_next;
    pins_t                    pins_reg,       pins_next;
    logic [BYTE_BITS-1:0]     send_buf_reg [STORE_BYTES];
    logic [BYTE_BITS-1:0]     rd_byte;
    logic [COUNT_WIDTH-1:0]   pos;
    logic [BIT_POS_WIDTH-1:0] bpos;

    always_comb begin
        rd_byte = '0;
        for (int i = 0; i < STORE_BYTES; i++) begin
            if (pos == COUNT_WIDTH'(i)) begin
                rd_byte = send_buf_reg[i];
            end
        end
    end

    always_comb begin
        phase_next      = phase_reg;
        byte_pos_next   = byte_pos_reg;
        bit_pos_next    = bit_pos_reg;
        half_next       = half_reg;
        byte_total_next = byte_total_reg;
        pins_next       = pins_reg;
        pos             = byte_pos_reg;
        bpos            = bit_pos_reg;
        case (item.kind)
            KIND_TICK: begin
                case (phase_reg)
                    PH_BEGIN: begin
                        byte_pos_next         = '0;
                        bit_pos_next          = '0;
                        half_next             = 1'b0;
                        pins_next.serial_data = 1'b0;
                        pins_next.latch_clock = 1'b0;
                        pins_next.shift_clock = 1'b0;
                        pins_next.enable_n    = 1'b1;
                        phase_next            = PH_STEP;
                    end
                    PH_STEP: begin
                        if (half_reg) begin
                            pins_next.shift_clock = 1'b0;
                            pins_next.serial_data = 1'b0;
                            bit_pos_next          = bit_pos_reg + BIT_POS_WIDTH'(1);
                            half_next             = 1'b0;
                        end else begin
                            if (bit_pos_reg >= BIT_POS_WIDTH'(BYTE_BITS)) begin
                                bpos = '0;
                                pos  = byte_pos_reg + COUNT_WIDTH'(1);
                            end
                            byte_pos_next = pos;
                            bit_pos_next  = bpos;
                            if (pos >= byte_total_reg || pos >= BUF_LIMIT) begin
                                phase_next = PH_FINISH;
                            end else begin
                                // msb first
                                pins_next.serial_data = rd_byte[~bpos[2:0]];
                                pins_next.shift_clock = 1'b1;
                                half_next             = 1'b1;
                            end
                        end
                    end
                    PH_FINISH: begin
                        if (half_reg) begin
                            pins_next.latch_clock = 1'b0;
                            pins_next.enable_n    = 1'b0;
                            half_next             = 1'b0;
                            phase_next            = PH_IDLE;
                        end else begin
                            pins_next.latch_clock = 1'b1;
                            half_next             = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            KIND_START: begin
                byte_total_next = (item.byte_count > BUF_LIMIT) ? BUF_LIMIT
                                                                : item.byte_count;
                phase_next      = PH_BEGIN;
            end
            KIND_ENABLE: begin
                pins_next.enable_n = ~item.enable_value;
            end
            default: begin
            end
        endcase
    end

    assign res_next.pins = pins_next;
    assign res_next.busy = (phase_next != PH_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            byte_pos_reg   <= '0;
            bit_pos_reg    <= '0;
            half_reg       <= 1'b0;
            byte_total_reg <= '0;
            pins_reg       <= '0;
            for (int i = 0; i < STORE_BYTES; i++) begin
                send_buf_reg[i] <= '0;
            end
        end else if (fire) begin
            phase_reg      <= phase_next;
            byte_pos_reg   <= byte_pos_next;
            bit_pos_reg    <= bit_pos_next;
            half_reg       <= half_next;
            byte_total_reg <= byte_total_next;
            pins_reg       <= pins_next;
            for (int i = 0; i < STORE_BYTES; i++) begin
                if (item.kind == KIND_LOAD &&
                    item.byte_index == INDEX_WIDTH'(i)) begin
                    send_buf_reg[i] <= item.byte_value;
                end
            end
        end
    end

`ifndef SYNTH
    a_half_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_IDLE) |-> !half_reg)
        else $error("half cycle set while idle");
    a_bit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        bit_pos_reg <= BIT_POS_WIDTH'(BYTE_BITS))
        else $error("bit position out of range");
    a_total_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        byte_total_reg <= BUF_LIMIT)
        else $error("byte total above buffer size");
`endif

endmodule

### tb/sv/serial_shift_register_loader_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_shift_register_loader_test
// Self-checking bench for the shift register loader. A scoreboard class keeps
// its own copy of the pin sequencer and the send buffer, predicts the pin
// levels and busy flag for every accepted input beat, and checks each output
// beat in order. Stimulus is a short directed run followed by random load,
// enable, start and tick sequences under three idle patterns, with pin
// inversion switched while the block is drained, plus long output stalls.
// ----------------------------------------------------------------------------
module serial_shift_register_loader_test
    import ssrl_pkg::*;
;

    localparam int BUFFER_BYTES = DEFAULT_BUFFER_BYTES;
    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 8;
    localparam int HOLD_CYCLES  = 64;
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int PHASE_BEATS  = 250;
    localparam int REPORT_LIMIT = 10;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_BEGIN,
        SEQ_SHIFT,
        SEQ_LATCH
    } seq_phase_t;

    class pin_scoreboard;
        logic                   invert;
        seq_phase_t             phase;
        logic [COUNT_WIDTH-1:0] byte_pos;
        logic [3:0]             bit_pos;
        logic                   half;
        logic [COUNT_WIDTH-1:0] byte_total;
        logic [7:0]             send_buf [BUFFER_BYTES];
        pins_t                  pins;
        res_t                   pin_queue [$];
        int unsigned            errors;
        int unsigned            checked;
        int unsigned            transfers;

        function new();
            invert     = INVERT_RESET;
            phase      = SEQ_IDLE;
            byte_pos   = '0;
            bit_pos    = '0;
            half       = 1'b0;
            byte_total = '0;
            pins       = '0;
            errors     = 0;
            checked    = 0;
            transfers  = 0;
            foreach (send_buf[i]) send_buf[i] = 8'h00;
        endfunction

        function bit busy();
            return phase != SEQ_IDLE;
        endfunction

        function int pending();
            return pin_queue.size();
        endfunction

        function void note_input(kind_t kind, logic [2:0] idx, logic [7:0] val,
                                 logic [6:0] cnt, logic en);
            res_t exp_res;
            case (kind)
                KIND_TICK: begin
                    case (phase)
                        SEQ_BEGIN: begin
                            byte_pos         = '0;
                            bit_pos          = '0;
                            half             = 1'b0;
                            pins.serial_data = 1'b0;
                            pins.latch_clock = 1'b0;
                            pins.shift_clock = 1'b0;
                            pins.enable_n    = 1'b1;
                            phase            = SEQ_SHIFT;
                        end
                        SEQ_SHIFT: begin
                            if (half) begin
                                pins.shift_clock = 1'b0;
                                pins.serial_data = 1'b0;
                                bit_pos          = bit_pos + 4'd1;
                                half             = 1'b0;
                            end else begin
                                if (bit_pos >= 4'd8) begin
                                    bit_pos  = '0;
                                    byte_pos = byte_pos + 7'd1;
                                end
                                if (byte_pos >= byte_total || byte_pos >= BUFFER_BYTES) begin
                                    phase = SEQ_LATCH;
                                end else begin
                                    pins.serial_data =
                                        send_buf[int'(byte_pos)][3'd7 - bit_pos[2:0]];
                                    pins.shift_clock = 1'b1;
                                    half             = 1'b1;
                                end
                            end
                        end
                        SEQ_LATCH: begin
                            if (half) begin
                                pins.latch_clock = 1'b0;
                                pins.enable_n    = 1'b0;
                                half             = 1'b0;
                                phase            = SEQ_IDLE;
                                transfers++;
                            end else begin
                                pins.latch_clock = 1'b1;
                                half             = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
                KIND_LOAD: begin
                    if (int'(idx) < BUFFER_BYTES) send_buf[int'(idx)] = val;
                end
                KIND_START: begin
                    byte_total = (int'(cnt) > BUFFER_BYTES) ? 7'(BUFFER_BYTES) : cnt;
                    phase      = SEQ_BEGIN;
                end
                default: begin
                    pins.enable_n = ~en;
                end
            endcase
            exp_res.pins = pins_t'(pins ^ {4{invert}});
            exp_res.busy = (phase != SEQ_IDLE);
            pin_queue.push_back(exp_res);
        endfunction

        function void check_result(logic sd, logic sc, logic lc, logic en_n, logic bsy);
            res_t exp_res;
            if (pin_queue.size() == 0) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("%0t: output beat with nothing expected", $time);
                return;
            end
            exp_res = pin_queue.pop_front();
            checked++;
            if (sd !== exp_res.pins.serial_data || sc !== exp_res.pins.shift_clock ||
                lc !== exp_res.pins.latch_clock || en_n !== exp_res.pins.enable_n ||
                bsy !== exp_res.busy) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("%0t: mismatch data/srck/rck/en_n/busy exp %b%b%b%b%b got %b%b%b%b%b",
                             $time, exp_res.pins.serial_data, exp_res.pins.shift_clock,
                             exp_res.pins.latch_clock, exp_res.pins.enable_n, exp_res.busy,
                             sd, sc, lc, en_n, bsy);
            end
        endfunction
    endclass

    logic       aclk           = 1'b0;
    logic       aresetn        = 1'b0;
    logic       cfg_wr_en      = 1'b0;
    logic       cfg_wr_data    = INVERT_RESET;
    logic       s_valid        = 1'b0;
    logic       s_ready;
    logic [1:0] s_kind         = '0;
    logic [2:0] s_byte_index   = '0;
    logic [7:0] s_byte_value   = '0;
    logic [6:0] s_byte_count   = '0;
    logic       s_enable_value = 1'b0;
    logic       m_valid;
    logic       m_ready        = 1'b0;
    logic       m_serial_data;
    logic       m_shift_clock;
    logic       m_latch_clock;
    logic       m_enable_n;
    logic       m_busy_res;

    pin_scoreboard sb;
    int unsigned   beats_sent  = 0;
    int            tx_idle_pct = 0;
    int            rx_idle_pct = 0;
    int unsigned   hold_req    = 0;
    int unsigned   hold_ack    = 0;
    int            hold_left   = 0;

    serial_shift_register_loader dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_kind         (s_kind),
        .s_byte_index   (s_byte_index),
        .s_byte_value   (s_byte_value),
        .s_byte_count   (s_byte_count),
        .s_enable_value (s_enable_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_serial_data  (m_serial_data),
        .m_shift_clock  (m_shift_clock),
        .m_latch_clock  (m_latch_clock),
        .m_enable_n     (m_enable_n),
        .m_busy_res     (m_busy_res)
    );

    always begin
        #HALF_PERIOD aclk = 1'b1;
        #HALF_PERIOD aclk = 1'b0;
    end

    // output side ready, with the long stall counted here
    always @(negedge aclk) begin
        if (hold_req != hold_ack) begin
            hold_left = HOLD_CYCLES;
            hold_ack  = hold_req;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_serial_data, m_shift_clock, m_latch_clock, m_enable_n,
                            m_busy_res);
    end

    initial begin : watchdog
        int unsigned n_cycles;
        n_cycles = 0;
        while (n_cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            n_cycles++;
        end
        $display("Some tests failed");
        $finish;
    end

    function automatic int pick_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 8'h00;
        if (r == 1) return 8'hff;
        return $urandom_range(0, 255);
    endfunction

    // a negative field means don't care: filled with random bits
    task automatic send_beat(input kind_t kind, input int idx, input int val,
                             input int cnt, input int en);
        if (idx < 0) idx = $urandom_range(0, 7);
        if (val < 0) val = $urandom_range(0, 255);
        if (cnt < 0) cnt = $urandom_range(0, 127);
        if (en < 0) en = $urandom_range(0, 1);
        @(negedge aclk);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_kind         <= kind;
        s_byte_index   <= 3'(idx);
        s_byte_value   <= 8'(val);
        s_byte_count   <= 7'(cnt);
        s_enable_value <= 1'(en);
        do @(posedge aclk); while (!s_ready);
        sb.note_input(kind, 3'(idx), 8'(val), 7'(cnt), 1'(en));
        beats_sent++;
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    task automatic write_invert(input logic value);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        sb.invert = value;
    endtask

    task automatic run_transfer();
        int n_loads;
        int cnt;
        int r;
        int guard;
        bit abandon;
        n_loads = $urandom_range(0, 3);
        if ($urandom_range(0, 9) == 0) send_beat(KIND_ENABLE, -1, -1, -1, -1);
        repeat (n_loads) send_beat(KIND_LOAD, -1, pick_byte(), -1, -1);
        r = $urandom_range(0, 99);
        if (r < 10) cnt = 0;
        else if (r < 70) cnt = $urandom_range(1, 2);
        else if (r < 92) cnt = $urandom_range(3, BUFFER_BYTES);
        else cnt = $urandom_range(BUFFER_BYTES + 1, 127);
        send_beat(KIND_START, -1, -1, cnt, -1);
        abandon = ($urandom_range(0, 99) < 8);
        guard   = abandon ? $urandom_range(1, 20) : 400;
        while (sb.busy() && guard > 0) begin
            r = $urandom_range(0, 199);
            if (r < 6) send_beat(KIND_LOAD, -1, pick_byte(), -1, -1);
            else if (r < 10) send_beat(KIND_ENABLE, -1, -1, -1, -1);
            else if (r == 10) send_beat(KIND_START, -1, -1, $urandom_range(0, 3), -1);
            else send_beat(KIND_TICK, -1, -1, -1, -1);
            guard--;
        end
        if ($urandom_range(0, 3) == 0) send_beat(KIND_TICK, -1, -1, -1, -1);
    endtask

    task automatic run_random(input int unsigned n_beats, input bit with_holds);
        int unsigned target;
        target = beats_sent + n_beats;
        if (with_holds) hold_req++;
        while (beats_sent < target) begin
            if ($urandom_range(0, 99) < 12) begin
                repeat ($urandom_range(1, 4))
                    send_beat(kind_t'($urandom_range(0, 3)), -1, -1, -1, -1);
            end else begin
                run_transfer();
            end
            if (with_holds && $urandom_range(0, 99) < 5) hold_req++;
            if ($urandom_range(0, 99) < 4) wait_drained();
        end
        while (sb.busy()) send_beat(KIND_TICK, -1, -1, -1, -1);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    initial begin : stimulus
        sb = new();
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: buffer extremes, idle tick, enable, zero count,
        // load and enable and restart while busy, saturated count
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_beat(KIND_LOAD, 0, 8'hff, -1, -1);
        send_beat(KIND_LOAD, 7, 8'h00, -1, -1);
        send_beat(KIND_LOAD, 1, 8'ha5, -1, -1);
        send_beat(KIND_TICK, -1, -1, -1, -1);
        send_beat(KIND_ENABLE, -1, -1, -1, 0);
        send_beat(KIND_ENABLE, -1, -1, -1, 1);
        send_beat(KIND_START, -1, -1, 0, -1);
        repeat (4) send_beat(KIND_TICK, -1, -1, -1, -1);
        send_beat(KIND_TICK, -1, -1, -1, -1);
        send_beat(KIND_START, -1, -1, 1, -1);
        repeat (2) send_beat(KIND_TICK, -1, -1, -1, -1);
        send_beat(KIND_LOAD, 0, 8'h5a, -1, -1);
        send_beat(KIND_TICK, -1, -1, -1, -1);
        send_beat(KIND_ENABLE, -1, -1, -1, 0);
        send_beat(KIND_TICK, -1, -1, -1, -1);
        send_beat(KIND_START, -1, -1, 127, -1);
        repeat (2) send_beat(KIND_TICK, -1, -1, -1, -1);
        send_beat(KIND_START, -1, -1, 64, -1);
        send_beat(KIND_START, -1, -1, 0, -1);
        repeat (4) send_beat(KIND_TICK, -1, -1, -1, -1);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        write_invert(1'b0);
        tx_idle_pct = 12;
        rx_idle_pct = 70;
        run_random(PHASE_BEATS, 1'b0);

        write_invert(1'b1);
        tx_idle_pct = 70;
        rx_idle_pct = 12;
        run_random(PHASE_BEATS, 1'b0);

        write_invert(1'($urandom_range(0, 1)));
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_random(PHASE_BEATS, 1'b1);

        if (sb.pending() != 0) sb.errors += sb.pending();
        $display("run covered %0d input beats, %0d output beats checked, %0d transfers latched",
                 beats_sent, sb.checked, sb.transfers);
        $display("pin inversion on and off, idle gaps on both sides, long output stalls");
        if (sb.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

### sim.f
design/ssrl_pkg.sv
design/ssrl_seq.sv
design/serial_shift_register_loader.sv
tb/sv/serial_shift_register_loader_test.sv
